[rtl/core/slsm_pkg.sv]
// Shared types and constants for the sorted-list set merge block.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package slsm_pkg;

	// List storage sizing
	localparam int LIST_DEPTH = 32;
	localparam int ID_WIDTH   = 32;
	localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Port widths fixed by the interface
	localparam int PORT_ID_W = 32;

	typedef logic [ID_WIDTH-1:0]  word_t;
	typedef logic [PORT_ID_W-1:0] port_id_t;

	// Action codes as they arrive on the input port
	localparam logic [1:0] ACT_FIRST  = 2'd0;
	localparam logic [1:0] ACT_SECOND = 2'd1;
	localparam logic [1:0] ACT_MERGE  = 2'd2;

	// Classified command carried through the queue
	typedef enum logic [1:0] {
		OP_LOAD_FIRST,
		OP_LOAD_SECOND,
		OP_MERGE
	} op_t;

	typedef struct packed {
		op_t   op;
		word_t id;
	} cmd_t;

	// Set operation selected by the mode register
	typedef enum logic [1:0] {
		MODE_UNION     = 2'd0,
		MODE_INTERSECT = 2'd1,
		MODE_DIFF      = 2'd2,
		MODE_SYMDIFF   = 2'd3
	} mode_t;

	// Back end sequencer
	typedef enum logic {
		B_IDLE,
		B_WALK
	} back_state_t;

endpackage

`default_nettype wire

[rtl/core/sorted_list_set_merge.sv]
// Top level of the sorted-list set merge block.
// Depends on slsm_pkg, slsm_front, slsm_queue and slsm_back.
//
//   channel   handshake                 payload
//   input     start / busy              action, doc_id
//   result    result_strobe (no stall)  result_id, present, last, overflow
//   config    cfg_valid / cfg_ready     set_mode
//
// A load is written to its list as it leaves the queue; the front register sits
// between the input port and the queue. A merge leaves the queue, then walks
// both lists, consuming one element at each step (a matching pair counts
// once), and a closing step emits the last item or the empty marker. busy
// rises only when the four-entry queue and the front register are both
// occupied. Reset clears both lists, the overflow flag and the mode register;
// the receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_set_merge (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  action,
	input  wire logic [31:0] doc_id,
	output logic             result_strobe,
	output logic [31:0]      result_id,
	output logic             present,
	output logic             last,
	output logic             overflow,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  set_mode
);
	import slsm_pkg::*;

	logic q_push, q_full, q_pop, q_empty;
	cmd_t push_cmd, q_head;

	// The mode register takes every write transfer
	assign cfg_ready = 1'b1;

	slsm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.action   (action),
		.doc_id   (doc_id),
		.q_full   (q_full),
		.push     (q_push),
		.push_cmd (push_cmd)
	);

	slsm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	slsm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_mode      (set_mode),
		.q_empty       (q_empty),
		.q_head        (q_head),
		.pop           (q_pop),
		.result_strobe (result_strobe),
		.result_id     (result_id),
		.present       (present),
		.last          (last),
		.overflow      (overflow)
	);

`ifndef SYNTHESIS
	// The empty-run marker is always the final item of its run
	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !present |-> last)
		else $error("empty marker without last");

	// A run closes with a dequeue cycle before anything else is emitted
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last |=> !result_strobe)
		else $error("result directly after last item");

	// No marker may follow a member of the same run
	a_no_marker_after_member: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && present && !last |=> !(result_strobe && !present))
		else $error("empty marker after a member");
`endif

endmodule

`default_nettype wire

[rtl/core/slsm_front.sv]
// Front end: takes input items, decodes the action and registers one command.
// Depends on slsm_pkg; feeds slsm_queue.
`timescale 1ns / 1ps
`default_nettype none

module slsm_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire logic [1:0]      action,
	input  wire logic [31:0]     doc_id,
	input  wire logic            q_full,
	output logic                 push,
	output slsm_pkg::cmd_t       push_cmd
);
	import slsm_pkg::*;

	logic  valid_s1;
	cmd_t  cmd_s1;
	logic  accept;
	logic  known;
	op_t   dec_op;

	// Decode the action; the unused code is dropped here
	always_comb begin
		known  = 1'b1;
		dec_op = OP_LOAD_FIRST;
		case (action)
			ACT_FIRST:  dec_op = OP_LOAD_FIRST;
			ACT_SECOND: dec_op = OP_LOAD_SECOND;
			ACT_MERGE:  dec_op = OP_MERGE;
			default:    known  = 1'b0;
		endcase
	end

	assign push   = valid_s1 && !q_full;
	assign busy   = valid_s1 && q_full;
	assign accept = start && !busy;

	// Hold the decoded command until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= known;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.op <= dec_op;
			cmd_s1.id <= ID_WIDTH'(doc_id);
		end
	end

	assign push_cmd = cmd_s1;

endmodule

`default_nettype wire

[rtl/core/slsm_queue.sv]
// Short command queue that decouples the front end from the back end.
// Depends on slsm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slsm_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire slsm_pkg::cmd_t  push_cmd,
	output logic                 full,
	input  wire logic            pop,
	output logic                 empty,
	output slsm_pkg::cmd_t       head
);
	import slsm_pkg::*;

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;

	assign full  = (fill_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (fill_q == '0);
	assign head  = slot_q[rd_ptr_q];

	// Advance pointers and fill count on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + QCNT_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

[rtl/core/slsm_back.sv]
// Back end: list storage, load execution and the two-pointer merge walk.
// Depends on slsm_pkg; takes commands from slsm_queue.
`timescale 1ns / 1ps
`default_nettype none

module slsm_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [1:0]      cfg_mode,
	input  wire logic            q_empty,
	input  wire slsm_pkg::cmd_t  q_head,
	output logic                 pop,
	output logic                 result_strobe,
	output logic [31:0]          result_id,
	output logic                 present,
	output logic                 last,
	output logic                 overflow
);
	import slsm_pkg::*;

	back_state_t state_q, state_d;
	mode_t       mode_q;

	word_t mem_a [LIST_DEPTH];
	word_t mem_b [LIST_DEPTH];
	word_t rd_a_q, rd_b_q;

	logic [CNT_W-1:0] cnt_a_q, cnt_b_q;
	logic [CNT_W-1:0] ptr_a_q, ptr_b_q;
	logic [CNT_W-1:0] ptr_a_d, ptr_b_d;
	logic             ovf_q;
	logic             pend_vld_q;
	word_t            pend_id_q;

	logic  a_has, b_has, a_lt, b_lt, eq, done;
	logic  take_a, take_b, take_both, adv_a, adv_b;
	logic  keep_a, keep_b, keep_both, keep;
	word_t cand_id;

	logic  wr_a, wr_b, set_ovf, clear_run;
	logic  emit, emit_present, emit_last, pend_load;
	word_t emit_id;

	// Which walk outcomes the selected set operation keeps
	assign keep_a    = (mode_q != MODE_INTERSECT);
	assign keep_b    = (mode_q == MODE_UNION) || (mode_q == MODE_SYMDIFF);
	assign keep_both = (mode_q == MODE_UNION) || (mode_q == MODE_INTERSECT);

	// One step of the two-pointer walk
	assign a_has     = (ptr_a_q < cnt_a_q);
	assign b_has     = (ptr_b_q < cnt_b_q);
	assign a_lt      = (rd_a_q < rd_b_q);
	assign b_lt      = (rd_b_q < rd_a_q);
	assign eq        = (rd_a_q == rd_b_q);
	assign take_a    = a_has && (!b_has || a_lt);
	assign take_b    = b_has && (!a_has || b_lt);
	assign take_both = a_has && b_has && eq;
	assign adv_a     = take_a || take_both;
	assign adv_b     = take_b || take_both;
	assign done      = !a_has && !b_has;
	assign keep      = (take_a && keep_a) || (take_b && keep_b) || (take_both && keep_both);
	assign cand_id   = take_b ? rd_b_q : rd_a_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_empty && q_head.op == OP_MERGE) begin
					state_d = B_WALK;
				end
			end
			B_WALK: begin
				if (done) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		pop          = 1'b0;
		wr_a         = 1'b0;
		wr_b         = 1'b0;
		set_ovf      = 1'b0;
		clear_run    = 1'b0;
		emit         = 1'b0;
		emit_present = 1'b1;
		emit_last    = 1'b0;
		emit_id      = pend_id_q;
		pend_load    = 1'b0;
		ptr_a_d      = '0;
		ptr_b_d      = '0;
		case (state_q)
			B_IDLE: begin
				pop = !q_empty;
				if (!q_empty) begin
					case (q_head.op)
						OP_LOAD_FIRST: begin
							wr_a    = (cnt_a_q < CNT_W'(LIST_DEPTH));
							set_ovf = !wr_a;
						end
						OP_LOAD_SECOND: begin
							wr_b    = (cnt_b_q < CNT_W'(LIST_DEPTH));
							set_ovf = !wr_b;
						end
						default: ;
					endcase
				end
			end
			B_WALK: begin
				if (done) begin
					// flush the held member as the final one, or the empty marker
					emit         = 1'b1;
					emit_last    = 1'b1;
					emit_present = pend_vld_q;
					emit_id      = pend_vld_q ? pend_id_q : '0;
					clear_run    = 1'b1;
				end else begin
					ptr_a_d   = ptr_a_q + CNT_W'(adv_a);
					ptr_b_d   = ptr_b_q + CNT_W'(adv_b);
					pend_load = keep;
					emit      = keep && pend_vld_q;
				end
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= B_IDLE;
			mode_q        <= MODE_UNION;
			cnt_a_q       <= '0;
			cnt_b_q       <= '0;
			ptr_a_q       <= '0;
			ptr_b_q       <= '0;
			ovf_q         <= 1'b0;
			pend_vld_q    <= 1'b0;
			result_strobe <= 1'b0;
		end else begin
			state_q       <= state_d;
			ptr_a_q       <= ptr_a_d;
			ptr_b_q       <= ptr_b_d;
			result_strobe <= emit;
			if (cfg_we) begin
				mode_q <= mode_t'(cfg_mode);
			end
			if (wr_a) begin
				cnt_a_q <= cnt_a_q + CNT_W'(1);
			end
			if (wr_b) begin
				cnt_b_q <= cnt_b_q + CNT_W'(1);
			end
			if (set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (pend_load) begin
				pend_vld_q <= 1'b1;
			end
			if (clear_run) begin
				cnt_a_q    <= '0;
				cnt_b_q    <= '0;
				ovf_q      <= 1'b0;
				pend_vld_q <= 1'b0;
			end
		end
	end

	// Hold the latest kept member; drive the result registers
	always_ff @(posedge clk) begin
		if (pend_load) begin
			pend_id_q <= cand_id;
		end
		if (emit) begin
			result_id <= PORT_ID_W'(emit_id);
			present   <= emit_present;
			last      <= emit_last;
			overflow  <= ovf_q;
		end
	end

	// List memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[cnt_a_q[IDX_W-1:0]] <= q_head.id;
		end
		rd_a_q <= mem_a[ptr_a_d[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (wr_b) begin
			mem_b[cnt_b_q[IDX_W-1:0]] <= q_head.id;
		end
		rd_b_q <= mem_b[ptr_b_d[IDX_W-1:0]];
	end

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the sorted-list set merge block.
// Depends on slsm_pkg and sorted_list_set_merge; predicts every merge run in a small tracker class.
`timescale 1ns / 1ps

module tb;
	import slsm_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 16;
	localparam int QUIET_LIMIT  = 2000;
	localparam int ITEM_TARGET  = 120;

	typedef struct {
		port_id_t id;
		bit       present;
		bit       last;
		bit       ovf;
	} result_item_t;

	// Mirror of both lists and the mode; holds the members each merge must emit
	class merge_tracker;
		port_id_t     first_ids[LIST_DEPTH];
		port_id_t     second_ids[LIST_DEPTH];
		int unsigned  first_len;
		int unsigned  second_len;
		bit           dropped;
		mode_t        op_mode;
		result_item_t merge_out_q[$];
		int           failures;
		int           overflow_runs;

		function new();
			first_len     = 0;
			second_len    = 0;
			dropped       = 1'b0;
			op_mode       = MODE_UNION;
			failures      = 0;
			overflow_runs = 0;
		endfunction

		function int pending();
			return merge_out_q.size();
		endfunction

		// Append to a list, drop the load once the list is full, or walk on a merge
		function void note_command(logic [1:0] act, port_id_t id);
			case (act)
				ACT_FIRST: begin
					if (first_len < LIST_DEPTH) begin
						first_ids[first_len] = id;
						first_len++;
					end else begin
						dropped = 1'b1;
					end
				end
				ACT_SECOND: begin
					if (second_len < LIST_DEPTH) begin
						second_ids[second_len] = id;
						second_len++;
					end else begin
						dropped = 1'b1;
					end
				end
				ACT_MERGE: walk_lists();
				default: ;
			endcase
		endfunction

		// Two-pointer walk over the stored order, then clear both lists
		function void walk_lists();
			int unsigned  i;
			int unsigned  j;
			bit           keep_a;
			bit           keep_b;
			bit           keep_both;
			port_id_t     members[$];
			result_item_t item;
			i = 0;
			j = 0;
			keep_a    = (op_mode != MODE_INTERSECT);
			keep_b    = (op_mode == MODE_UNION || op_mode == MODE_SYMDIFF);
			keep_both = (op_mode == MODE_UNION || op_mode == MODE_INTERSECT);
			while (i < first_len && j < second_len) begin
				if (first_ids[i] < second_ids[j]) begin
					if (keep_a) members.insert(members.size(), first_ids[i]);
					i++;
				end else if (second_ids[j] < first_ids[i]) begin
					if (keep_b) members.insert(members.size(), second_ids[j]);
					j++;
				end else begin
					if (keep_both) members.insert(members.size(), first_ids[i]);
					i++;
					j++;
				end
			end
			for (; i < first_len; i++)
				if (keep_a) members.insert(members.size(), first_ids[i]);
			for (; j < second_len; j++)
				if (keep_b) members.insert(members.size(), second_ids[j]);
			item.ovf = dropped;
			if (members.size() == 0) begin
				item.id      = '0;
				item.present = 1'b0;
				item.last    = 1'b1;
				merge_out_q.insert(merge_out_q.size(), item);
			end else begin
				foreach (members[k]) begin
					item.id      = members[k];
					item.present = 1'b1;
					item.last    = (k == members.size() - 1);
					merge_out_q.insert(merge_out_q.size(), item);
				end
			end
			if (dropped) overflow_runs++;
			first_len  = 0;
			second_len = 0;
			dropped    = 1'b0;
		endfunction

		function void compare(string field, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
				failures++;
			end
		endfunction

		function void check_result(port_id_t id, bit present, bit last, bit ovf);
			result_item_t want;
			if (merge_out_q.size() == 0) begin
				$display("%0t: result id %0h with nothing outstanding", $time, id);
				failures++;
				return;
			end
			want = merge_out_q[0];
			merge_out_q.delete(0);
			compare("result_id", want.id, id);
			compare("present", want.present, present);
			compare("last", want.last, last);
			compare("overflow", want.ovf, ovf);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  action = '0;
	logic [31:0] doc_id = '0;
	logic        cfg_valid = 1'b0;
	logic [1:0]  set_mode = '0;
	logic        cfg_ready;
	logic        busy;
	logic        result_strobe;
	logic [31:0] result_id;
	logic        present;
	logic        last;
	logic        overflow;

	merge_tracker tracker = new();
	int   quiet_cycles = 0;
	int   n_cmds = 0;
	int   n_merges = 0;
	int   n_results = 0;
	int   n_sent = 0;
	bit   [3:0] modes_seen = '0;

	sorted_list_set_merge DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.doc_id(doc_id),
		.result_strobe(result_strobe),
		.result_id(result_id),
		.present(present),
		.last(last),
		.overflow(overflow),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.set_mode(set_mode)
	);

	always #5 clk = ~clk;

	// Sample every transfer at the rising edge; results first, then the new command, then a mode write
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (result_strobe) begin
				tracker.check_result(result_id, present, last, overflow);
				n_results++;
				quiet_cycles = 0;
			end
			if (start && !busy) begin
				tracker.note_command(action, doc_id);
				if (action != ACT_UNUSED) n_cmds++;
				if (action == ACT_MERGE) n_merges++;
				quiet_cycles = 0;
			end
			if (cfg_valid && cfg_ready) begin
				tracker.op_mode = mode_t'(set_mode);
				quiet_cycles = 0;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Random idle length: each cycle idles with a chance of about 22 in 100; no idling while n_sent is 60 to 99
	function automatic int idle_gap();
		int g;
		g = 0;
		if (n_sent >= 60 && n_sent < 100) return 0;
		while ($urandom_range(0, 99) < 22) g++;
		return g;
	endfunction

	function automatic port_id_t rand_id();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 63);
			1: return $urandom_range(32'hFFFF_FFC0, 32'hFFFF_FFFF);
			default: return $urandom;
		endcase
	endfunction

	// Insert keeping ascending order; refuse duplicates
	function automatic bit add_sorted(ref port_id_t q[$], input port_id_t v);
		int pos;
		pos = 0;
		while (pos < q.size() && q[pos] < v) pos++;
		if (pos < q.size() && q[pos] == v) return 1'b0;
		q.insert(pos, v);
		return 1'b1;
	endfunction

	function automatic void shuffle_ids(ref port_id_t q[$]);
		int       j;
		port_id_t t;
		for (int k = 0; k < q.size(); k++) begin
			j    = $urandom_range(0, q.size() - 1);
			t    = q[k];
			q[k] = q[j];
			q[j] = t;
		end
	endfunction

	// Offer one command and hold it until a transfer
	task automatic send(input logic [1:0] act, input port_id_t id);
		int g;
		g = idle_gap();
		if (g > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
		@(negedge clk);
		start  <= 1'b1;
		action <= act;
		doc_id <= id;
		do @(posedge clk); while (busy);
		if (act != ACT_UNUSED) n_sent++;
	endtask

	// Drop start, wait for every outstanding result, then let the queue drain
	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_mode(input mode_t m);
		wait_idle();
		repeat (idle_gap()) @(negedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		set_mode  <= m;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		modes_seen[m] = 1'b1;
	endtask

	// Load two lists with random content in random interleave, then merge
	task automatic run_query(input int n_first, input int n_second, input bit scramble);
		port_id_t fa[$];
		port_id_t fb[$];
		port_id_t v;
		int       i;
		int       j;
		while (fa.size() < n_first) void'(add_sorted(fa, rand_id()));
		while (fb.size() < n_second) begin
			if (fa.size() > 0 && $urandom_range(0, 99) < 40)
				v = fa[$urandom_range(0, fa.size() - 1)];
			else
				v = rand_id();
			void'(add_sorted(fb, v));
		end
		if (scramble) begin
			shuffle_ids(fa);
			shuffle_ids(fb);
		end
		i = 0;
		j = 0;
		while (i < fa.size() || j < fb.size()) begin
			if ($urandom_range(0, 99) < 6) begin
				send(ACT_UNUSED, $urandom);
			end else if (j >= fb.size() || (i < fa.size() && $urandom_range(0, 1))) begin
				send(ACT_FIRST, fa[i]);
				i++;
			end else begin
				send(ACT_SECOND, fb[j]);
				j++;
			end
		end
		send(ACT_MERGE, $urandom);
	endtask

	initial begin
		mode_t phase_order[4];
		int    phase;
		int    kind;
		int    errors;
		phase_order = '{MODE_SYMDIFF, MODE_DIFF, MODE_UNION, MODE_INTERSECT};

		// Hold reset, then release it on a falling clock edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty merge, field extremes, ignored action, unsorted lists
		write_mode(MODE_UNION);
		send(ACT_MERGE, 32'hFFFF_FFFF);
		send(ACT_FIRST, 32'h0000_0000);
		send(ACT_SECOND, 32'h0000_0001);
		send(ACT_FIRST, 32'h0000_0001);
		send(ACT_SECOND, 32'h7FFF_FFFF);
		send(ACT_FIRST, 32'h8000_0000);
		send(ACT_FIRST, 32'hFFFF_FFFF);
		send(ACT_UNUSED, 32'h5A5A_A5A5);
		send(ACT_SECOND, 32'hFFFF_FFFF);
		send(ACT_MERGE, 32'h0000_0000);
		send(ACT_FIRST, 32'd9);
		send(ACT_FIRST, 32'd3);
		send(ACT_SECOND, 32'd4);
		send(ACT_MERGE, 32'h1234_5678);

		// Disjoint intersection gives the empty marker
		write_mode(MODE_INTERSECT);
		send(ACT_FIRST, 32'd2);
		send(ACT_SECOND, 32'd3);
		send(ACT_FIRST, 32'd4);
		send(ACT_SECOND, 32'd5);
		send(ACT_MERGE, 32'd0);

		// Random phases, one mode each; the second phase opens with an overflow
		phase = 0;
		while (n_sent < ITEM_TARGET) begin
			write_mode(phase < 4 ? phase_order[phase] : mode_t'($urandom_range(0, 3)));
			for (int qn = 0; qn < 3 && n_sent < ITEM_TARGET; qn++) begin
				kind = $urandom_range(0, 99);
				if (kind < 8 || (phase == 1 && qn == 0)) begin
					if ($urandom_range(0, 1))
						run_query(LIST_DEPTH + $urandom_range(1, 3), $urandom_range(0, 6), 1'b0);
					else
						run_query($urandom_range(0, 6), LIST_DEPTH + $urandom_range(1, 3), 1'b0);
				end else if (kind < 16) begin
					run_query($urandom_range(16, LIST_DEPTH), $urandom_range(16, LIST_DEPTH), 1'b0);
				end else if (kind < 26) begin
					run_query($urandom_range(1, 8), $urandom_range(1, 8), 1'b1);
				end else if (kind < 31) begin
					run_query(0, 0, 1'b0);
				end else begin
					run_query($urandom_range(0, 8), $urandom_range(0, 8), 1'b0);
				end
			end
			phase++;
		end

		wait_idle();
		errors = tracker.failures + tracker.pending();
		if (tracker.pending() != 0)
			$display("%0t: %0d result items never arrived", $time, tracker.pending());
		$display("Covered %0d commands and %0d merges, %0d result items checked.",
			n_cmds, n_merges, n_results);
		$display("Set modes exercised %b, %0d merges reported overflow.",
			modes_seen, tracker.overflow_runs);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
